// File: design/dqec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqec_pkg
// Shared types and constants for the dual quadrature encoder counter.
// ----------------------------------------------------------------------------
package dqec_pkg;

	// Counter width, fixed by the snapshot format
	localparam int CountW  = 32;
	localparam int ActionW = 2;
	localparam int FlagsW  = 8;
	localparam int SnapW   = 5 * CountW;

	// Request kinds carried on tuser
	typedef enum logic [ActionW-1:0] {
		ACT_EDGE  = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_RESET = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Pin flags for one wheel
	typedef struct packed {
		logic a_edge;
		logic b_edge;
		logic a_level;
		logic b_level;
	} wheel_pins_t;

	// Control for one lane, decoded from the request
	typedef struct packed {
		logic    en;
		action_t action;
	} lane_ctrl_t;

endpackage

// File: design/dqec_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqec_lane
// One wheel: x2 quadrature decode, window count, running total and speed.
// ----------------------------------------------------------------------------
module dqec_lane #(
	parameter bit NegSpeed = 1'b0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dqec_pkg::lane_ctrl_t      ctrl,
	input  dqec_pkg::wheel_pins_t     pins,
	output logic [dqec_pkg::CountW-1:0] total,
	output logic [dqec_pkg::CountW-1:0] speed
);
	import dqec_pkg::*;

	logic [CountW-1:0] window_q;
	logic [CountW-1:0] total_q;
	logic [CountW-1:0] speed_q;
	logic [2:0]        delta;
	logic [CountW-1:0] delta_ext;
	logic [CountW-1:0] win_scaled;

	// Sum the signed steps of both phases (range -2..2)
	always_comb begin
		delta = 3'd0;
		if (pins.a_edge) begin
			delta = pins.b_level ? 3'd1 : 3'b111;
		end
		if (pins.b_edge) begin
			delta = delta + (pins.a_level ? 3'b111 : 3'd1);
		end
		delta_ext = {{(CountW-3){delta[2]}}, delta};
	end

	// Scale window by four, negate for a mirrored wheel
	assign win_scaled = NegSpeed ? ((CountW'(0) - window_q) << 2) : (window_q << 2);

	// Update counters on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			total_q  <= '0;
			speed_q  <= '0;
		end else if (ctrl.en) begin
			case (ctrl.action)
				ACT_EDGE: begin
					window_q <= window_q + delta_ext;
					total_q  <= total_q + delta_ext;
				end
				ACT_TICK: begin
					speed_q  <= win_scaled;
					window_q <= '0;
				end
				ACT_RESET: begin
					window_q <= '0;
					total_q  <= '0;
					speed_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign total = total_q;
	assign speed = speed_q;

endmodule

// File: design/dqec_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqec_merge
// Combines both lanes into the output snapshot register.
// ----------------------------------------------------------------------------
module dqec_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  logic                        ready,
	input  logic [dqec_pkg::CountW-1:0] total_left,
	input  logic [dqec_pkg::CountW-1:0] total_right,
	input  logic [dqec_pkg::CountW-1:0] speed_left,
	input  logic [dqec_pkg::CountW-1:0] speed_right,
	output logic                        advance,
	output logic                        valid_s2,
	output logic [dqec_pkg::SnapW-1:0]  snap_s2
);
	import dqec_pkg::*;

	logic [CountW-1:0] diff;
	logic [CountW-1:0] half;

	// Halve the difference, truncating toward zero
	assign diff = total_left - total_right;
	assign half = CountW'($signed(diff + {{(CountW-1){1'b0}}, diff[CountW-1]}) >>> 1);

	// Move the snapshot forward when the output register is free
	assign advance = !valid_s2 || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			snap_s2 <= {half, speed_right, speed_left, total_right, total_left};
		end
	end

endmodule

// File: design/dual_quadrature_encoder_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_quadrature_encoder_counter_top
// Two-wheel x2 quadrature counter returning a snapshot for every request.
//
//  Channel  Dir  Signals                        Contents
//  s        in   s_tvalid s_tready s_tdata s_tuser  pin flags, action
//  m        out  m_tvalid m_tready m_tdata          totals, speeds, distance
//
// One request per clock while the m side is not stalled; m_tvalid rises after
// acceptance (lane counters update at the accepting edge, then the snapshot/distance
// register loads once the output register is free or draining).
// arst_n clears all counters and both pipeline valids.
// A stalled m side holds the snapshot; s_tready drops only when both the
// lane stage and the output register are occupied and m_tready is low.
// ----------------------------------------------------------------------------
module dual_quadrature_encoder_counter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] left_a_edge [1] left_b_edge [2] right_a_edge [3] right_b_edge
	// [4] left_a_level [5] left_b_level [6] right_a_level [7] right_b_level
	input  logic [dqec_pkg::FlagsW-1:0]   s_tdata,
	// [1:0] action
	input  logic [dqec_pkg::ActionW-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] total_left_out [63:32] total_right_out [95:64] speed_left_out
	// [127:96] speed_right_out [159:128] distance_pulses
	output logic [dqec_pkg::SnapW-1:0]    m_tdata
);
	import dqec_pkg::*;

	logic          valid_s1;
	logic          advance;
	logic          accept;
	lane_ctrl_t    ctrl;
	wheel_pins_t   pins_left;
	wheel_pins_t   pins_right;
	logic [CountW-1:0] total_left;
	logic [CountW-1:0] total_right;
	logic [CountW-1:0] speed_left;
	logic [CountW-1:0] speed_right;

	// Take a request when the lane stage is empty or draining
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	assign ctrl.en     = accept;
	assign ctrl.action = action_t'(s_tuser);

	assign pins_left  = '{a_edge: s_tdata[0], b_edge: s_tdata[1],
	                      a_level: s_tdata[4], b_level: s_tdata[5]};
	assign pins_right = '{a_edge: s_tdata[2], b_edge: s_tdata[3],
	                      a_level: s_tdata[6], b_level: s_tdata[7]};

	// Track the snapshot held in the lane counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	dqec_lane #(.NegSpeed(1'b0)) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.pins   (pins_left),
		.total  (total_left),
		.speed  (speed_left)
	);

	dqec_lane #(.NegSpeed(1'b1)) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.pins   (pins_right),
		.total  (total_right),
		.speed  (speed_right)
	);

	dqec_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.ready       (m_tready),
		.total_left  (total_left),
		.total_right (total_right),
		.speed_left  (speed_left),
		.speed_right (speed_right),
		.advance     (advance),
		.valid_s2    (m_tvalid),
		.snap_s2     (m_tdata)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual quadrature encoder counter. A queue of pin
// requests (edge events, sample ticks, resets and the spare action code) is
// fed through the s stream with random gaps. Each accepted request advances a
// local copy of the window, total and speed counters, and the resulting
// snapshot is queued. Every snapshot leaving the m stream is compared field by
// field against the oldest queued one, while the m side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
	import dqec_pkg::*;

	localparam int          LimitCycles = 200000;
	localparam int          TailItems   = 150;
	localparam int          LongHoldAt  = 300;
	localparam int          LongHold    = 60;
	localparam int          RandomItems = 1130;
	localparam int          MaxReports  = 40;
	localparam logic [31:0] SpeedScale  = 32'd4;
	localparam int          DistDiv     = 2;

	typedef struct {
		action_t     act;
		wheel_pins_t left;
		wheel_pins_t right;
		bit          wait_idle;
	} pin_req_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [FlagsW-1:0]  s_tdata  = '0;
	logic [ActionW-1:0] s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [SnapW-1:0]   m_tdata;

	// Stimulus and expected snapshots
	pin_req_t         pin_requests[$];
	logic [SnapW-1:0] snapshots_due[$];
	pin_req_t         offered;
	bit               req_taken   = 1'b0;
	int               send_gap    = 0;
	int               hold_left   = 0;
	bit               long_done   = 1'b0;
	int               n_accepted  = 0;
	int               n_errors    = 0;
	int               cycles      = 0;

	// Local copy of the block's counters
	logic [31:0] win_l, win_r, tot_l, tot_r, spd_l, spd_r;

	string field_name[5] = '{"total_left_out", "total_right_out", "speed_left_out",
		"speed_right_out", "distance_pulses"};

	dual_quadrature_encoder_counter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Net step of one wheel: each flagged phase edge counts one up or down
	function automatic logic [31:0] wheel_delta(wheel_pins_t p);
		logic [31:0] d;
		d = '0;
		if (p.a_edge)
			d = p.b_level ? d + 32'd1 : d - 32'd1;
		if (p.b_edge)
			d = p.a_level ? d - 32'd1 : d + 32'd1;
		return d;
	endfunction

	// Apply one request to the counters and return the snapshot that follows
	function automatic logic [SnapW-1:0] update_counters(pin_req_t r);
		logic [31:0]        dl, dr;
		logic signed [31:0] diff, half_diff;
		dl = wheel_delta(r.left);
		dr = wheel_delta(r.right);
		case (r.act)
			ACT_EDGE: begin
				win_l = win_l + dl;
				tot_l = tot_l + dl;
				win_r = win_r + dr;
				tot_r = tot_r + dr;
			end
			ACT_TICK: begin
				spd_l = win_l * SpeedScale;
				spd_r = (32'd0 - win_r) * SpeedScale;
				win_l = '0;
				win_r = '0;
			end
			ACT_RESET: begin
				win_l = '0;
				win_r = '0;
				tot_l = '0;
				tot_r = '0;
				spd_l = '0;
				spd_r = '0;
			end
			default: ;
		endcase
		diff = tot_l - tot_r;
		half_diff = diff / DistDiv;
		return {half_diff, spd_r, spd_l, tot_r, tot_l};
	endfunction

	function automatic void add_req(action_t a, wheel_pins_t l, wheel_pins_t r,
			bit wait_idle = 1'b0);
		pin_req_t q;
		q.act       = a;
		q.left      = l;
		q.right     = r;
		q.wait_idle = wait_idle;
		pin_requests.push_back(q);
	endfunction

	// Pins of one wheel turning: dir 0 still, 1 forward, 2 backward
	function automatic wheel_pins_t spin(int dir);
		wheel_pins_t p;
		int          k;
		p = wheel_pins_t'($urandom_range(0, 15));
		k = $urandom_range(0, 2);
		if (dir == 0) begin
			p.a_edge = 1'b0;
			p.b_edge = 1'b0;
		end else begin
			p.a_edge = (k != 1);
			p.b_edge = (k != 0);
			if (p.a_edge)
				p.b_level = (dir == 1);
			if (p.b_edge)
				p.a_level = (dir != 1);
		end
		return p;
	endfunction

	task automatic report_fault(string msg);
		if (n_errors < MaxReports)
			$display("ERROR @%0t: %s", $realtime, msg);
		n_errors++;
	endtask

	// Sender: offer the next request once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (req_taken && pin_requests.size() > TailItems && $urandom_range(0, 4) == 0)
				send_gap = $urandom_range(1, 9);
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pin_requests.size() == 0 ||
					(pin_requests[0].wait_idle && snapshots_due.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				offered = pin_requests.pop_front();
				s_tdata <= {offered.right.b_level, offered.right.a_level,
					offered.left.b_level, offered.left.a_level,
					offered.right.b_edge, offered.right.a_edge,
					offered.left.b_edge, offered.left.a_edge};
				s_tuser  <= offered.act;
				s_tvalid <= 1'b1;
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off, none in the tail
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!long_done && n_accepted >= LongHoldAt) begin
			long_done = 1'b1;
			hold_left = LongHold - 1;
			m_tready <= 1'b0;
		end else if (pin_requests.size() > TailItems && $urandom_range(0, 6) == 0) begin
			hold_left = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: check leaving snapshots, then predict for the accepted request
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (snapshots_due.size() == 0) begin
					report_fault($sformatf("unexpected snapshot %h", m_tdata));
				end else begin
					logic [SnapW-1:0] want;
					want = snapshots_due.pop_front();
					for (int i = 0; i < 5; i++)
						if (m_tdata[i*32 +: 32] !== want[i*32 +: 32])
							report_fault($sformatf("%s got %0d expected %0d", field_name[i],
								$signed(m_tdata[i*32 +: 32]), $signed(want[i*32 +: 32])));
				end
			end
			req_taken = s_tvalid && s_tready;
			if (req_taken) begin
				snapshots_due.push_back(update_counters(offered));
				n_accepted++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LimitCycles) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int n, run, dir_l, dir_r;
		win_l = '0;
		win_r = '0;
		tot_l = '0;
		tot_r = '0;
		spd_l = '0;
		spd_r = '0;

		// Directed: every edge/level combination, ignored flags, spare action
		add_req(ACT_RESET, 4'b1111, 4'b1111);
		add_req(ACT_EDGE,  4'b1000, 4'b0000);
		add_req(ACT_EDGE,  4'b1001, 4'b1000);
		add_req(ACT_EDGE,  4'b0100, 4'b0110);
		add_req(ACT_EDGE,  4'b0110, 4'b0100);
		add_req(ACT_EDGE,  4'b1101, 4'b1110);
		add_req(ACT_EDGE,  4'b1111, 4'b1100);
		add_req(ACT_EDGE,  4'b0011, 4'b0011);
		add_req(ACT_TICK,  4'b1111, 4'b1111);
		add_req(ACT_NONE,  4'b1101, 4'b1101);
		repeat (3) add_req(ACT_EDGE, 4'b1110, 4'b1101);
		add_req(ACT_TICK,  4'b0000, 4'b0000);
		add_req(ACT_TICK,  4'b0000, 4'b0000);
		add_req(ACT_EDGE,  4'b1101, 4'b1110);
		add_req(ACT_NONE,  4'b0000, 4'b0000);
		add_req(ACT_RESET, 4'b0000, 4'b0000);
		add_req(ACT_EDGE,  4'b1000, 4'b1000);
		add_req(ACT_TICK,  4'b0000, 4'b0000);
		add_req(ACT_EDGE,  4'b0101, 4'b1010, 1'b1);

		// Random: mostly runs of turning wheels with ticks, plus noise
		n = 0;
		while (n < RandomItems) begin
			if ($urandom_range(0, 3) != 0) begin
				run   = $urandom_range(5, 60);
				dir_l = $urandom_range(0, 2);
				dir_r = $urandom_range(0, 2);
				repeat (run) begin
					if ($urandom_range(0, 9) == 0)
						add_req(ACT_TICK, wheel_pins_t'($urandom_range(0, 15)),
							wheel_pins_t'($urandom_range(0, 15)));
					else
						add_req(ACT_EDGE, spin(dir_l), spin(dir_r));
					n++;
				end
			end else begin
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 39) == 0)
						add_req(ACT_RESET, wheel_pins_t'($urandom_range(0, 15)),
							wheel_pins_t'($urandom_range(0, 15)));
					else
						add_req(action_t'($urandom_range(0, 3)),
							wheel_pins_t'($urandom_range(0, 15)),
							wheel_pins_t'($urandom_range(0, 15)));
					n++;
				end
			end
		end
		// Hold the sender once mid-run until every snapshot is back
		pin_requests[pin_requests.size() / 2].wait_idle = 1'b1;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pin_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (snapshots_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
